[sv/nstp_pkg.sv]
// ----------------------------------------------------------------------------
// Nested section time profiler package
// Shared constants, status codes, types and a saturating-add helper function.
// ----------------------------------------------------------------------------
package nstp_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int PROBES      = 64;
   localparam int SP_W        = $clog2(STACK_DEPTH);
   localparam int DP_W        = $clog2(STACK_DEPTH + 1);
   localparam int SLOT_W      = $clog2(PROBES + 1);
   localparam int ID_W        = 7;
   localparam int TS_W        = 64;
   localparam int CNT_W       = 32;
   localparam int ST_W        = 3;
   localparam int OP_W        = 2;

   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [ST_W-1:0] ST_OK        = 3'd0;
   localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd1;
   localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd2;
   localparam logic [ST_W-1:0] ST_MISMATCH  = 3'd3;
   localparam logic [ST_W-1:0] ST_BADID     = 3'd4;

   typedef struct packed {
      logic [TS_W-1:0]  best;
      logic [TS_W-1:0]  worst;
      logic [TS_W-1:0]  sum;
      logic [CNT_W-1:0] count;
   } stat_type;

   // par_excl: parent's exclusive time at the moment this frame was pushed
   typedef struct packed {
      logic [ID_W-1:0] probe;
      logic [TS_W-1:0] start;
      logic [TS_W-1:0] excl;
      logic [TS_W-1:0] par_excl;
   } frame_type;

   function automatic logic [TS_W-1:0] sat_add(input logic [TS_W-1:0] a,
                                               input logic [TS_W-1:0] b);
      logic [TS_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TS_W] ? {TS_W{1'b1}} : s[TS_W-1:0];
   endfunction

endpackage

[sv/nstp_stack.sv]
// ----------------------------------------------------------------------------
// Section stack memory
// Open section frames in two banks sharing one read address: timing fields
// (start, exclusive time) and link fields (probe, parent time), each with
// its own write enable.
// ----------------------------------------------------------------------------
module nstp_stack (
   input  logic                              clock,
   input  logic [nstp_pkg::SP_W-1:0]         rd_addr,
   output nstp_pkg::frame_type               rd_data,
   input  logic                              wr_en,
   input  logic                              wr_link_en,
   input  logic [nstp_pkg::SP_W-1:0]         wr_addr,
   input  nstp_pkg::frame_type               wr_data
);
   import nstp_pkg::*;

   logic [2*TS_W-1:0]    time_mem [STACK_DEPTH];
   logic [ID_W+TS_W-1:0] link_mem [STACK_DEPTH];
   logic [2*TS_W-1:0]    time_rd_ff;
   logic [ID_W+TS_W-1:0] link_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr] <= {wr_data.start, wr_data.excl};
      end
      if (wr_link_en) begin
         link_mem[wr_addr] <= {wr_data.probe, wr_data.par_excl};
      end
      time_rd_ff <= time_mem[rd_addr];
      link_rd_ff <= link_mem[rd_addr];
   end

   assign rd_data = {link_rd_ff[ID_W+TS_W-1:TS_W], time_rd_ff, link_rd_ff[TS_W-1:0]};

endmodule

[sv/nstp_stats.sv]
// ----------------------------------------------------------------------------
// Statistics memory
// Per-slot best, worst, sum and count with valid bits for reset values.
// ----------------------------------------------------------------------------
module nstp_stats (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [nstp_pkg::SLOT_W-1:0]       rd_addr,
   output nstp_pkg::stat_type                rd_data,
   input  logic                              wr_en,
   input  logic [nstp_pkg::SLOT_W-1:0]       wr_addr,
   input  nstp_pkg::stat_type                wr_data
);
   import nstp_pkg::*;

   stat_type         mem [PROBES+1];
   stat_type         rd_ff;
   logic             rd_valid_ff;
   logic [PROBES:0]  valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_comb begin
      if (rd_valid_ff) begin
         rd_data = rd_ff;
      end else begin
         rd_data.best  = '1;
         rd_data.worst = '0;
         rd_data.sum   = '0;
         rd_data.count = '0;
      end
   end

endmodule

[sv/nested_section_time_profiler_core.sv]
// ----------------------------------------------------------------------------
// Nested section time profiler core
// Channel   | ports               | transfer
// request   | req_*, start, busy  | start & !busy
// response  | rsp_*, rsp_valid    | one cycle strobe, no back-pressure
// Each event has two steps: memory read, then update and write-back.
// busy is high for the cycle after acceptance; the result strobes in the
// cycle after that.
// Reset is synchronous; stack contents are not cleared, stats use valid bits.
// The receiver cannot stall; a new event may start in the strobe cycle.
// ----------------------------------------------------------------------------
module nested_section_time_profiler_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [nstp_pkg::OP_W-1:0]         req_opcode,
   input  logic [nstp_pkg::ID_W-1:0]         req_probe_id,
   input  logic [nstp_pkg::TS_W-1:0]         req_timestamp,
   output logic                              rsp_valid,
   output logic [nstp_pkg::ST_W-1:0]         rsp_status,
   output logic [nstp_pkg::TS_W-1:0]         rsp_best_time,
   output logic [nstp_pkg::TS_W-1:0]         rsp_worst_time,
   output logic [nstp_pkg::TS_W-1:0]         rsp_total_time,
   output logic [nstp_pkg::CNT_W-1:0]        rsp_event_count,
   output logic [nstp_pkg::ID_W-1:0]         rsp_nesting_depth
);
   import nstp_pkg::*;

   logic                 ph_ff;
   logic [OP_W-1:0]      op_ff;
   logic [ID_W-1:0]      id_ff;
   logic [TS_W-1:0]      ts_ff;
   logic [DP_W-1:0]      dp_ff, dp_in;
   logic [TS_W-1:0]      idle_ff, idle_in;
   logic [SP_W-1:0]      top_addr;
   logic [SLOT_W-1:0]    st_raddr;
   frame_type            top_q, sk_wdata;
   logic                 sk_we;
   logic                 sk_link_we;
   logic [SP_W-1:0]      sk_waddr;
   stat_type             st_q, st_wdata;
   logic                 st_we;
   logic [SLOT_W-1:0]    st_waddr;
   logic [ST_W-1:0]      status;
   logic                 rd_out;
   logic [TS_W-1:0]      t_rec, t_int, t_acc;
   logic                 accept;

   assign accept = start && !busy;
   assign busy   = ph_ff;

   // top frame lies below the pointer
   assign top_addr = SP_W'(dp_ff - DP_W'(1));
   always_comb begin
      if (req_opcode == OP_START && dp_ff == '0) begin
         st_raddr = SLOT_W'(PROBES);
      end else if (req_opcode == OP_READ) begin
         st_raddr = SLOT_W'(req_probe_id);
      end else begin
         st_raddr = SLOT_W'(req_probe_id);
      end
   end

   nstp_stack u_stack (
      .clock      (clock),
      .rd_addr    (top_addr),
      .rd_data    (top_q),
      .wr_en      (sk_we),
      .wr_link_en (sk_link_we),
      .wr_addr    (sk_waddr),
      .wr_data    (sk_wdata)
   );

   nstp_stats u_stats (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (st_raddr),
      .rd_data (st_q),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata)
   );

   always_comb begin
      status     = ST_OK;
      rd_out     = 1'b0;
      sk_we      = 1'b0;
      sk_link_we = 1'b0;
      sk_waddr   = top_addr;
      sk_wdata   = top_q;
      st_we      = 1'b0;
      st_waddr   = SLOT_W'(id_ff);
      dp_in      = dp_ff;
      idle_in    = idle_ff;
      t_int      = ts_ff - top_q.start;
      t_acc      = sat_add(top_q.excl, t_int);
      t_rec      = t_acc;
      if (op_ff == OP_START) begin
         t_rec = ts_ff - idle_ff;
         if (id_ff >= ID_W'(PROBES)) begin
            status = ST_BADID;
         end else if (dp_ff >= DP_W'(STACK_DEPTH)) begin
            status = ST_OVERFLOW;
         end else begin
            if (dp_ff == '0) begin
               st_we    = 1'b1;
               st_waddr = SLOT_W'(PROBES);
            end
            // push: the parent's exclusive time so far rides in the new frame
            sk_we             = 1'b1;
            sk_link_we        = 1'b1;
            sk_waddr          = SP_W'(dp_ff);
            sk_wdata.probe    = id_ff;
            sk_wdata.start    = ts_ff;
            sk_wdata.excl     = '0;
            sk_wdata.par_excl = (dp_ff == '0) ? '0 : t_acc;
            dp_in             = dp_ff + DP_W'(1);
         end
      end else if (op_ff == OP_STOP) begin
         if (id_ff >= ID_W'(PROBES)) begin
            status = ST_BADID;
         end else if (dp_ff == '0) begin
            status = ST_UNDERFLOW;
         end else if (top_q.probe != id_ff) begin
            status = ST_MISMATCH;
         end else begin
            st_we = 1'b1;
            dp_in = dp_ff - DP_W'(1);
            if (dp_ff == DP_W'(1)) begin
               idle_in = ts_ff;
            end else begin
               // parent resumes now
               sk_we          = 1'b1;
               sk_waddr       = SP_W'(dp_ff - DP_W'(2));
               sk_wdata.start = ts_ff;
               sk_wdata.excl  = top_q.par_excl;
            end
         end
      end else if (op_ff == OP_READ) begin
         if (id_ff > ID_W'(PROBES)) begin
            status = ST_BADID;
         end else begin
            rd_out = 1'b1;
         end
      end
      st_wdata.best  = (t_rec < st_q.best) ? t_rec : st_q.best;
      st_wdata.worst = (t_rec > st_q.worst) ? t_rec : st_q.worst;
      st_wdata.sum   = sat_add(st_q.sum, t_rec);
      st_wdata.count = (st_q.count == '1) ? st_q.count : st_q.count + CNT_W'(1);
      if (!ph_ff) begin
         sk_we      = 1'b0;
         sk_link_we = 1'b0;
         st_we      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_opcode;
         id_ff <= req_probe_id;
         ts_ff <= req_timestamp;
      end
      rsp_status        <= status;
      rsp_best_time     <= rd_out ? st_q.best : '0;
      rsp_worst_time    <= rd_out ? st_q.worst : '0;
      rsp_total_time    <= rd_out ? st_q.sum : '0;
      rsp_event_count   <= rd_out ? st_q.count : '0;
      rsp_nesting_depth <= ID_W'(dp_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff     <= 1'b0;
         rsp_valid <= 1'b0;
         dp_ff     <= '0;
         idle_ff   <= '0;
      end else begin
         ph_ff     <= accept;
         rsp_valid <= ph_ff;
         if (ph_ff) begin
            dp_ff   <= dp_in;
            idle_ff <= idle_in;
         end
      end
   end

   `ifndef SYNTH
   a_depth_step: assert property (@(posedge clock) disable iff (reset)
      ph_ff |=> (dp_ff == $past(dp_ff) || dp_ff == $past(dp_ff) + DP_W'(1)
                 || dp_ff == $past(dp_ff) - DP_W'(1)))
      else $error("depth moved by more than one");
   a_depth_max: assert property (@(posedge clock) disable iff (reset)
      dp_ff <= DP_W'(STACK_DEPTH))
      else $error("depth beyond stack");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !ph_ff || $past(accept))
      else $error("response overlap");
   a_we_phase: assert property (@(posedge clock) disable iff (reset)
      (sk_we || sk_link_we || st_we) |-> ph_ff)
      else $error("write outside update cycle");
   `endif

endmodule
